[hdl/nbg_pkg.sv]
`default_nettype none

package nbg_pkg;

    localparam int ID_W  = 16;
    localparam int CFG_W = 5;
    localparam int LEN_W = 6;
    localparam int IDX_W = 5;
    localparam int OFF_W = 8;

    localparam logic [CFG_W-1:0] MAX_GROUP_BYTES_RST = 5'd8;

    typedef logic [1:0] state_t;

    localparam state_t ST_IDLE = 2'd0;
    localparam state_t ST_UPD  = 2'd1;
    localparam state_t ST_EMIT = 2'd2;

    // One outgoing record byte
    typedef struct packed {
        logic [ID_W-1:0]  base_id;
        logic [LEN_W-1:0] record_length;
        logic [IDX_W-1:0] byte_index;
        logic [7:0]       bitmap_byte;
        logic             record_end;
        logic             last;
    } result_t;

endpackage

`default_nettype wire

[hdl/nbg_ram.sv]
`default_nettype none

module nbg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hdl/nack_bitmap_grouper_top.sv]
// An id that only opens a group is taken in IDLE; an id that sets a bit reads its byte
// from the bitmap RAM in IDLE and writes it back in UPD. A record is walked out of the
// RAM byte by byte (read, then output register load), stalled while an output byte waits.
// No id is taken outside IDLE; one id can emit up to BITMAP_BYTES+1 bytes (two records).
// Reset (aresetn low, synchronous): no open group, span register back to 8, output empty,
// all bitmap valid flags cleared; RAM contents stay, masked to zero by the flags.
`default_nettype none

module nack_bitmap_grouper_top #(
    parameter int BITMAP_BYTES = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [4:0]  cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_missing_id,
    input  wire logic        s_end_of_set,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_base_id,
    output logic [5:0]       m_record_length,
    output logic [4:0]       m_byte_index,
    output logic [7:0]       m_bitmap_byte,
    output logic             m_record_end,
    output logic             m_last
);

    localparam int AW = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
    localparam logic [nbg_pkg::OFF_W-1:0] SPAN_CAP = nbg_pkg::OFF_W'(8 * BITMAP_BYTES - 1);

    nbg_pkg::state_t                 state_reg, state_next;
    logic [nbg_pkg::CFG_W-1:0]       cfg_reg, cfg_next;
    logic                            open_reg, open_next;
    logic [nbg_pkg::ID_W-1:0]        base_reg, base_next;
    logic [nbg_pkg::OFF_W-1:0]       high_reg, high_next;
    logic [BITMAP_BYTES-1:0]         valid_reg, valid_next;
    logic [nbg_pkg::ID_W-1:0]        id_reg, id_next;
    logic                            eos_reg, eos_next;
    logic [AW-1:0]                   waddr_reg, waddr_next;
    logic [2:0]                      wbit_reg, wbit_next;
    logic                            after_open_reg, after_open_next;
    logic [nbg_pkg::IDX_W-1:0]       k_reg, k_next;
    logic                            rd_pend_reg, rd_pend_next;
    logic                            vld_q_reg;
    logic                            out_valid_reg, out_valid_next;
    nbg_pkg::result_t                out_reg, out_next;

    logic                            in_acc;
    logic [nbg_pkg::ID_W-1:0]        off;
    logic [nbg_pkg::OFF_W-1:0]       cfg_span;
    logic [nbg_pkg::OFF_W-1:0]       span;
    logic                            far;
    logic [AW-1:0]                   off_addr;
    logic [nbg_pkg::IDX_W-1:0]       last_k;
    logic [nbg_pkg::LEN_W-1:0]       rec_len;
    logic                            emit_end;
    logic                            ram_re;
    logic                            ram_we;
    logic [AW-1:0]                   ram_raddr;
    logic [7:0]                      ram_rdata;
    logic [7:0]                      rd_data_eff;
    logic [7:0]                      ram_wdata;

    nbg_ram #(
        .WIDTH (8),
        .DEPTH (BITMAP_BYTES)
    ) u_bitmap_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (waddr_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready  = (state_reg == nbg_pkg::ST_IDLE);
    assign in_acc   = s_valid && s_ready;
    assign off      = s_missing_id - base_reg;
    assign cfg_span = {cfg_reg, 3'b000};
    assign span     = (cfg_span < SPAN_CAP) ? cfg_span : SPAN_CAP;
    assign far      = off > {8'd0, span};
    assign off_addr = off[AW+2:3];
    assign last_k   = high_reg[7:3];
    assign rec_len  = {1'b0, last_k} + 6'd3;
    assign emit_end = (k_reg == last_k);

    // Never-written bytes of the current group read as zero
    assign rd_data_eff = vld_q_reg ? ram_rdata : 8'd0;
    assign ram_wdata   = rd_data_eff | 8'(8'd1 << wbit_reg);

    always_comb begin
        state_next      = state_reg;
        cfg_next        = cfg_reg;
        open_next       = open_reg;
        base_next       = base_reg;
        high_next       = high_reg;
        valid_next      = valid_reg;
        id_next         = id_reg;
        eos_next        = eos_reg;
        waddr_next      = waddr_reg;
        wbit_next       = wbit_reg;
        after_open_next = after_open_reg;
        k_next          = k_reg;
        rd_pend_next    = rd_pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        ram_re          = 1'b0;
        ram_we          = 1'b0;
        ram_raddr       = k_reg[AW-1:0];

        if (cfg_wr_en) begin
            cfg_next = cfg_wr_data;
        end

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            nbg_pkg::ST_IDLE: begin
                if (in_acc) begin
                    id_next  = s_missing_id;
                    eos_next = s_end_of_set;
                    k_next   = '0;
                    if (open_reg && far) begin
                        // Close the old record first, open the new group after it
                        after_open_next = 1'b1;
                        state_next      = nbg_pkg::ST_EMIT;
                    end else if (!open_reg) begin
                        open_next       = 1'b1;
                        base_next       = s_missing_id;
                        high_next       = '0;
                        valid_next      = '0;
                        after_open_next = 1'b0;
                        if (s_end_of_set) begin
                            state_next = nbg_pkg::ST_EMIT;
                        end
                    end else if (off != '0) begin
                        ram_re     = 1'b1;
                        ram_raddr  = off_addr;
                        waddr_next = off_addr;
                        wbit_next  = off[2:0];
                        if (off[7:0] > high_reg) begin
                            high_next = off[7:0];
                        end
                        after_open_next = 1'b0;
                        state_next      = nbg_pkg::ST_UPD;
                    end else if (s_end_of_set) begin
                        after_open_next = 1'b0;
                        state_next      = nbg_pkg::ST_EMIT;
                    end
                end
            end
            nbg_pkg::ST_UPD: begin
                ram_we                = 1'b1;
                valid_next[waddr_reg] = 1'b1;
                k_next                = '0;
                state_next            = eos_reg ? nbg_pkg::ST_EMIT : nbg_pkg::ST_IDLE;
            end
            nbg_pkg::ST_EMIT: begin
                if (rd_pend_reg) begin
                    rd_pend_next           = 1'b0;
                    out_valid_next         = 1'b1;
                    out_next.base_id       = base_reg;
                    out_next.record_length = rec_len;
                    out_next.byte_index    = k_reg;
                    out_next.bitmap_byte   = rd_data_eff;
                    out_next.record_end    = emit_end;
                    out_next.last          = emit_end && !(after_open_reg && eos_reg);
                    if (emit_end) begin
                        k_next = '0;
                        if (after_open_reg) begin
                            open_next       = 1'b1;
                            base_next       = id_reg;
                            high_next       = '0;
                            valid_next      = '0;
                            after_open_next = 1'b0;
                            if (!eos_reg) begin
                                state_next = nbg_pkg::ST_IDLE;
                            end
                        end else begin
                            open_next  = 1'b0;
                            state_next = nbg_pkg::ST_IDLE;
                        end
                    end else begin
                        k_next = k_reg + 5'd1;
                    end
                end else if (!out_valid_reg || m_ready) begin
                    // Output register is free by the time this byte returns
                    ram_re       = 1'b1;
                    rd_pend_next = 1'b1;
                end
            end
            default: begin
                state_next = nbg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= nbg_pkg::ST_IDLE;
            cfg_reg        <= nbg_pkg::MAX_GROUP_BYTES_RST;
            open_reg       <= 1'b0;
            base_reg       <= '0;
            high_reg       <= '0;
            valid_reg      <= '0;
            after_open_reg <= 1'b0;
            k_reg          <= '0;
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cfg_reg        <= cfg_next;
            open_reg       <= open_next;
            base_reg       <= base_next;
            high_reg       <= high_next;
            valid_reg      <= valid_next;
            after_open_reg <= after_open_next;
            k_reg          <= k_next;
            rd_pend_reg    <= rd_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg    <= id_next;
        eos_reg   <= eos_next;
        waddr_reg <= waddr_next;
        wbit_reg  <= wbit_next;
        out_reg   <= out_next;
        if (ram_re) begin
            vld_q_reg <= valid_reg[ram_raddr];
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_base_id       = out_reg.base_id;
    assign m_record_length = out_reg.record_length;
    assign m_byte_index    = out_reg.byte_index;
    assign m_bitmap_byte   = out_reg.bitmap_byte;
    assign m_record_end    = out_reg.record_end;
    assign m_last          = out_reg.last;

    a_last_ends_record: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_last || m_record_end))
        else $error("last flag on a byte that does not end its record");

    a_end_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_record_end) |-> ({1'b0, m_byte_index} + 6'd3 == m_record_length))
        else $error("record ends at a byte index that does not match its length");

    a_read_only_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> (state_reg == nbg_pkg::ST_EMIT))
        else $error("bitmap read pending outside record emission");

    a_load_into_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> !out_valid_reg)
        else $error("bitmap byte returned while output register still full");

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    // Tracks the open NACK group and queues the record bytes it must produce.
    class nack_record_board;
        nbg_pkg::result_t pending_bytes[$];
        int         errors;
        logic [4:0] span_bytes;
        logic       grp_open;
        logic [15:0] grp_base;
        logic [7:0] top_offset;
        logic [7:0] bitmap[32];

        function new();
            errors     = 0;
            span_bytes = nbg_pkg::MAX_GROUP_BYTES_RST;
            grp_open   = 1'b0;
            grp_base   = '0;
            top_offset = '0;
            foreach (bitmap[i]) bitmap[i] = '0;
        endfunction

        function void set_span(logic [4:0] v);
            span_bytes = v;
        endfunction

        function int span_limit();
            int lim;
            lim = int'(span_bytes) * 8;
            if (lim > 32 * 8 - 1) lim = 32 * 8 - 1;
            return lim;
        endfunction

        function int pending_count();
            return pending_bytes.size();
        endfunction

        function void open_group(logic [15:0] id);
            grp_open   = 1'b1;
            grp_base   = id;
            top_offset = '0;
            foreach (bitmap[i]) bitmap[i] = '0;
        endfunction

        function int emit_record();
            int               nbytes;
            nbg_pkg::result_t r;
            nbytes = int'(top_offset) / 8 + 1;
            for (int k = 0; k < nbytes; k++) begin
                r.base_id       = grp_base;
                r.record_length = 6'(2 + nbytes);
                r.byte_index    = 5'(k);
                r.bitmap_byte   = bitmap[k];
                r.record_end    = (k == nbytes - 1);
                r.last          = 1'b0;
                pending_bytes   = {pending_bytes, r};
            end
            return nbytes;
        endfunction

        function void note_request(logic [15:0] id, logic eos);
            logic [15:0] off;
            int          n;
            n = 0;
            if (grp_open) begin
                off = id - grp_base;
                if (int'(off) > span_limit()) begin
                    n += emit_record();
                    open_group(id);
                end else if (off != 0) begin
                    bitmap[off[7:3]] |= 8'(1) << off[2:0];
                    if (off[7:0] > top_offset) top_offset = off[7:0];
                end
            end else begin
                open_group(id);
            end
            if (eos) begin
                n += emit_record();
                grp_open = 1'b0;
            end
            // flag the final byte caused by this request
            if (n > 0) begin
                pending_bytes[pending_bytes.size() - 1].last = 1'b1;
            end
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            end
        endfunction

        function void check_byte(nbg_pkg::result_t got);
            nbg_pkg::result_t want;
            if (pending_bytes.size() == 0) begin
                errors++;
                $display("%0t: unexpected record byte, expected none, actual base_id %0h idx %0d",
                         $time, got.base_id, got.byte_index);
                return;
            end
            want = pending_bytes.pop_front();
            compare("base_id", want.base_id, got.base_id);
            compare("record_length", want.record_length, got.record_length);
            compare("byte_index", want.byte_index, got.byte_index);
            compare("bitmap_byte", want.bitmap_byte, got.bitmap_byte);
            compare("record_end", want.record_end, got.record_end);
            compare("last", want.last, got.last);
        endfunction
    endclass

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic [4:0]  cfg_wr_data  = '0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [15:0] s_missing_id = '0;
    logic        s_end_of_set = 1'b0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [15:0] m_base_id;
    logic [5:0]  m_record_length;
    logic [4:0]  m_byte_index;
    logic [7:0]  m_bitmap_byte;
    logic        m_record_end;
    logic        m_last;

    nack_record_board board = new();
    int          tx_idle_pct  = 0;
    int          rx_stall_pct = 0;
    logic [15:0] last_id      = '0;
    nbg_pkg::result_t seen_byte;

    nack_bitmap_grouper_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_missing_id    (s_missing_id),
        .s_end_of_set    (s_end_of_set),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_base_id       (m_base_id),
        .m_record_length (m_record_length),
        .m_byte_index    (m_byte_index),
        .m_bitmap_byte   (m_bitmap_byte),
        .m_record_end    (m_record_end),
        .m_last          (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_byte.base_id       = m_base_id;
            seen_byte.record_length = m_record_length;
            seen_byte.byte_index    = m_byte_index;
            seen_byte.bitmap_byte   = m_bitmap_byte;
            seen_byte.record_end    = m_record_end;
            seen_byte.last          = m_last;
            board.check_byte(seen_byte);
        end
    end

    task automatic send_request(input logic [15:0] id, input logic eos);
        s_valid      <= 1'b1;
        s_missing_id <= id;
        s_end_of_set <= eos;
        do @(posedge aclk); while (!s_ready);
        board.note_request(id, eos);
        last_id = id;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // Hold the sender until every queued record byte has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.pending_count() != 0);
    endtask

    task automatic settle();
        wait_drained();
        repeat (8) @(posedge aclk);
    endtask

    task automatic program_span(input logic [4:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        board.set_span(v);
    endtask

    // Mostly ascending id runs closed by end of set; the rest is noise.
    task automatic send_traffic(input int n_items, input int pause_at);
        int          sent;
        int          run_len;
        int          lim;
        int          gap;
        logic [15:0] id;
        sent = 0;
        while (sent < n_items) begin
            if (sent == pause_at) wait_drained();
            if ($urandom_range(99) < 15) begin
                case ($urandom_range(2))
                    0:       id = 16'($urandom_range(65535));
                    1:       id = last_id;
                    default: id = last_id - 16'($urandom_range(1, 20));
                endcase
                send_request(id, 1'($urandom_range(1)));
                sent++;
            end else begin
                lim     = board.span_limit();
                run_len = $urandom_range(1, 12);
                id      = 16'($urandom_range(65535));
                for (int k = 0; k < run_len && sent < n_items; k++) begin
                    if (k > 0) begin
                        case ($urandom_range(9))
                            0:       gap = lim + $urandom_range(1, 40);
                            1, 2:    gap = $urandom_range(1, lim + 1);
                            default: gap = $urandom_range(1, lim / 4 + 1);
                        endcase
                        id = id + 16'(gap);
                    end
                    send_request(id, k == run_len - 1);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        logic [4:0] spans[8];
        spans = '{5'd31, 5'd1, 5'd8, 5'd0, 5'd17, 5'd31, 5'd4, 5'd24};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset span of 8 bytes: offsets up to 64 stay in the group
        send_request(16'h0000, 1'b0);
        send_request(16'h0000, 1'b0);
        send_request(16'h0001, 1'b0);
        send_request(16'h0040, 1'b0);
        send_request(16'h0041, 1'b1);
        send_request(16'hFFFF, 1'b1);
        send_request(16'h0064, 1'b0);
        send_request(16'h005A, 1'b0);
        send_request(16'h005F, 1'b0);
        send_request(16'h005D, 1'b0);
        send_request(16'h005C, 1'b1);
        settle();

        // widest span: full 32-byte bitmap, then one past it
        program_span(5'd31);
        send_request(16'h8000, 1'b0);
        send_request(16'h8007, 1'b0);
        send_request(16'h80F8, 1'b0);
        send_request(16'h80F9, 1'b1);
        settle();

        program_span(5'd0);
        send_request(16'h1234, 1'b0);
        send_request(16'h1234, 1'b0);
        send_request(16'h1235, 1'b0);
        send_request(16'h1236, 1'b1);
        settle();

        program_span(5'd1);
        send_request(16'h7FF0, 1'b0);
        send_request(16'h7FF8, 1'b1);
        settle();

        for (int p = 0; p < 8; p++) begin
            program_span(spans[p]);
            case (p % 4)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 57; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 57; end
                default: begin tx_idle_pct = 7;  rx_stall_pct = 7;  end
            endcase
            send_traffic(35, (p == 5) ? 17 : -1);
            settle();
        end

        if (board.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
